// ----- rtl/rde_pkg.sv -----
// Package for the radix digit emitter: field widths, ASCII constants,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package rde_pkg;

    localparam int VALUE_W        = 32;
    localparam int BASE_W         = 5;
    localparam int DIGIT_W        = 4;
    localparam int CHAR_W         = 7;
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_MAX_BASE   = 16;

    localparam logic [CHAR_W-1:0]  DIGIT_ZERO         = 7'd48;
    localparam logic [CHAR_W-1:0]  LETTER_OFFSET      = 7'd55;
    localparam logic [DIGIT_W-1:0] FIRST_LETTER_DIGIT = 4'd10;
    localparam logic [BASE_W-1:0]  MIN_BASE           = 5'd2;

    typedef struct packed {
        logic load;      // take a new request
        logic div_step;  // one restoring-division bit
        logic push;      // store remainder digit
        logic rd;        // issue stack read, pop count
        logic out_load;  // capture character into output register
    } rde_cmd_t;

    typedef struct packed {
        logic step_last;  // final bit of the current division
        logic quot_zero;  // running quotient is zero
        logic out_last;   // output register holds the final character
    } rde_status_t;

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        return (d < FIRST_LETTER_DIGIT) ? DIGIT_ZERO + dx : dx + LETTER_OFFSET;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rde_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rde_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rde_ctrl.sv -----
// Controller FSM of the radix digit emitter: sequences division, digit
// push, stack pop and output handshake. Depends on rde_pkg.
`default_nettype none

module rde_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output rde_pkg::rde_cmd_t         cmd,
    input  wire rde_pkg::rde_status_t status
);
    import rde_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_PUSH = 6'b000100,
        ST_RD   = 6'b001000,
        ST_WAIT = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.step_last) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                cmd.push   = 1'b1;
                state_next = status.quot_zero ? ST_RD : ST_DIV;
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = status.out_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

endmodule

`default_nettype wire

// ----- rtl/rde_dpath.sv -----
// Datapath of the radix digit emitter: bit-serial restoring divider,
// digit stack in RAM, output character register. Depends on rde_pkg, rde_ram.
`default_nettype none

module rde_dpath #(
    parameter int VALUE_BITS = rde_pkg::DEF_VALUE_BITS,
    parameter int MAX_BASE   = rde_pkg::DEF_MAX_BASE
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rde_pkg::rde_cmd_t             cmd,
    output rde_pkg::rde_status_t               status,
    input  wire logic [rde_pkg::VALUE_W-1:0]   in_value,
    input  wire logic [rde_pkg::BASE_W-1:0]    in_base,
    output logic      [rde_pkg::CHAR_W-1:0]    out_char,
    output logic                               out_last
);
    import rde_pkg::*;

    localparam int QW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int AW = $clog2(QW);
    localparam int CW = $clog2(QW + 1);
    localparam logic [BASE_W-1:0] MAXB   = BASE_W'(MAX_BASE);
    localparam logic [AW-1:0]     STEP_END = AW'(QW - 1);

    logic [QW-1:0]      quot_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [AW-1:0]      step_reg;
    logic [CW-1:0]      count_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [BASE_W-1:0]  base_clamped;
    logic [BASE_W-1:0]  trial;
    logic               trial_ge;
    logic [BASE_W-1:0]  trial_diff;
    logic [CW-1:0]      count_dec;
    logic [DIGIT_W-1:0] stack_rdata;

    always_comb begin
        if (in_base < MIN_BASE) begin
            base_clamped = MIN_BASE;
        end else if (in_base > MAXB) begin
            base_clamped = MAXB;
        end else begin
            base_clamped = in_base;
        end
    end

    // restoring division: shift the next dividend bit into the remainder
    assign trial      = {rem_reg, quot_reg[QW-1]};
    assign trial_ge   = (trial >= base_reg);
    assign trial_diff = trial - base_reg;
    assign count_dec  = count_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quot_reg  <= '0;
            rem_reg   <= '0;
            base_reg  <= MIN_BASE;
            step_reg  <= '0;
            count_reg <= '0;
            last_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                quot_reg  <= in_value[QW-1:0];
                rem_reg   <= '0;
                base_reg  <= base_clamped;
                step_reg  <= '0;
                count_reg <= '0;
            end
            if (cmd.div_step) begin
                quot_reg <= {quot_reg[QW-2:0], trial_ge};
                rem_reg  <= trial_ge ? trial_diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.push) begin
                count_reg <= count_reg + 1'b1;
                rem_reg   <= '0;
                step_reg  <= '0;
            end
            if (cmd.rd) begin
                count_reg <= count_dec;
            end
            if (cmd.out_load) begin
                last_reg <= (count_reg == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            char_reg <= ascii_of(stack_rdata);
        end
    end

    rde_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (QW)
    ) u_stack (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (count_reg[AW-1:0]),
        .wdata (rem_reg),
        .re    (cmd.rd),
        .raddr (count_dec[AW-1:0]),
        .rdata (stack_rdata)
    );

    assign status.step_last = (step_reg == STEP_END);
    assign status.quot_zero = (quot_reg == '0);
    assign status.out_last  = last_reg;
    assign out_char         = char_reg;
    assign out_last         = last_reg;

endmodule

`default_nettype wire

// ----- rtl/radix_digit_emitter_top.sv -----
// Radix digit emitter: unsigned value to base-N ASCII digits, MSB first.
// One request at a time. Each digit comes from bit-serial restoring division
// over QW = min(VALUE_BITS, 32) quotient bits and is pushed onto the digit stack;
// each character is popped, converted to ASCII and held until m_tready takes it.
// Synchronous active-low reset returns the controller to idle; no clearing pass.
`default_nettype none

module radix_digit_emitter_top #(
    parameter int VALUE_BITS = rde_pkg::DEF_VALUE_BITS,
    parameter int MAX_BASE   = rde_pkg::DEF_MAX_BASE
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] value, [36:32] base, [39:37] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [6:0] digit_char, [7] zero
    output logic             m_tlast    // last_digit
);
    import rde_pkg::*;

    rde_cmd_t          cmd;
    rde_status_t       status;
    logic [CHAR_W-1:0] out_char;

    rde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    rde_dpath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_BASE   (MAX_BASE)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_value (s_tdata[VALUE_W-1:0]),
        .in_base  (s_tdata[VALUE_W+BASE_W-1:VALUE_W]),
        .out_char (out_char),
        .out_last (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

    // never accept a new request while a character is pending
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("request accepted while output pending");

    // final character hands control back to the input side
    a_last_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("input not ready after final character");

    // more characters follow a non-final one
    a_more_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("stream ended without last flag");

endmodule

`default_nettype wire
